>>> rtl/sdfd_pkg.sv
`default_nettype none

package sdfd_pkg;

    localparam int ELEV_BITS      = 16;
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int ROW_BITS       = 13;
    localparam int ROW_LIMIT      = 4096;
    localparam int COORD_BITS     = 12;
    localparam int SLOPE_BITS     = 32;
    localparam int CODE_BITS      = 4;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 13;
    localparam int DIM_RESET      = 1024;
    localparam int DIAG_SCALE     = 46341;   // 1/sqrt2 in Q16
    localparam int ORTHO_SHIFT    = 16;
    localparam int NUM_NB         = 8;
    localparam int OUTQ_DEPTH     = 8;

    localparam logic [ROW_BITS-1:0] ROW_MAX = {ROW_BITS{1'b1}};

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef enum logic [CODE_BITS-1:0] {
        DIR_NW   = 4'd0,
        DIR_N    = 4'd1,
        DIR_NE   = 4'd2,
        DIR_W    = 4'd3,
        DIR_E    = 4'd4,
        DIR_SW   = 4'd5,
        DIR_S    = 4'd6,
        DIR_SE   = 4'd7,
        DIR_NONE = 4'd8
    } dir_t;

    typedef logic [ELEV_BITS-1:0] elev_t;

    typedef struct packed {
        logic  func;
        elev_t elevation;
    } in_item_t;

    typedef struct packed {
        logic [CODE_BITS-1:0]  direction_code;
        logic [SLOPE_BITS-1:0] slope_q16;
        logic [COORD_BITS-1:0] cell_col;
        logic [COORD_BITS-1:0] cell_row;
        logic                  frame_last;
    } out_item_t;

    // 3x3 window, index (dy+1)*3 + (dx+1)
    typedef logic [8:0][ELEV_BITS-1:0] window_t;

    typedef struct packed {
        logic                  emit;
        logic                  last;
        logic                  up_ok;
        logic                  down_ok;
        logic                  left_ok;
        logic                  right_ok;
        logic [COORD_BITS-1:0] cell_col;
        logic [COORD_BITS-1:0] cell_row;
    } meta_t;

    typedef struct packed {
        logic [SLOPE_BITS-1:0] slope;
        logic [CODE_BITS-1:0]  code;
    } cand_t;

    // zero reads as one, anything above hi reads as hi
    function automatic logic [CFG_DATA_BITS-1:0] clamp_dim(
        input logic [CFG_DATA_BITS-1:0] v,
        input logic [CFG_DATA_BITS-1:0] hi
    );
        logic [CFG_DATA_BITS-1:0] r;
        if (v == '0)
            r = CFG_DATA_BITS'(1);
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

    // earlier candidate keeps a tie
    function automatic cand_t pick(input cand_t a, input cand_t b);
        cand_t r;
        if (b.slope > a.slope)
            r = b;
        else
            r = a;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/steepest_descent_flow_direction_core.sv
// Steepest-descent flow direction over a raster heightmap stream.
// in channel: one elevation (or flush pad) per transaction, raster order.
// out channel: direction code, Q16.16 slope and centre coordinates per
//   centre cell; at most one result per input transaction.
// cfg channel: grid_width (index 0) and grid_height (index 1); always
//   ready, and a write restarts the frame at column 0, row 0. Write only
//   while no results are outstanding.
// Results trail the input by one row plus one cell; push flush items after
//   the last row so it drains. An accepted item passes stages s1 to s5 and
//   then the output queue before its result shows on out.
// Throughput: one transaction per cycle while in_ready is high. The line stores
//   sit in one single-port-write RAM, read at accept and written back the cycle after.
// A credit counter caps the 5-stage pipe plus the 8-entry output queue at
//   eight transactions; in_ready drops only when out has been stalled long
//   enough to fill it.
// Reset: position returns to zero, grid is 1024 x 1024, queue empties. Line
//   store contents are not cleared and are never used before being written.
`default_nettype none

module steepest_descent_flow_direction_core #(
    parameter int MAX_WIDTH = sdfd_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output      logic                                 in_ready,
    input  wire sdfd_pkg::in_item_t                   in_item,
    output      logic                                 out_valid,
    input  wire logic                                 out_ready,
    output      sdfd_pkg::out_item_t                  out_item,
    input  wire logic                                 cfg_valid,
    output      logic                                 cfg_ready,
    input  wire logic [sdfd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [sdfd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int NBITS = $clog2(sdfd_pkg::OUTQ_DEPTH + 1);

    logic                in_accept;
    logic                pop;
    logic                win_valid;
    sdfd_pkg::window_t   win;
    sdfd_pkg::meta_t     win_meta;
    logic                retire;
    logic                push;
    logic                drop_out;
    sdfd_pkg::out_item_t push_item;
    logic [NBITS-1:0]    pending_reg, pending_next;

    assign cfg_ready = 1'b1;
    assign in_ready  = (pending_reg < NBITS'(sdfd_pkg::OUTQ_DEPTH));
    assign in_accept = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign drop_out  = retire && !push;

    // items in flight plus results queued
    assign pending_next = pending_reg + NBITS'(in_accept) - NBITS'(drop_out) - NBITS'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    sdfd_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .in_item   (in_item),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .win_valid (win_valid),
        .win       (win),
        .win_meta  (win_meta)
    );

    sdfd_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .win_valid (win_valid),
        .win       (win),
        .win_meta  (win_meta),
        .retire    (retire),
        .push      (push),
        .push_item (push_item)
    );

    sdfd_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

>>> rtl/sdfd_ram.sv
`default_nettype none

module sdfd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/sdfd_front.sv
`default_nettype none

module sdfd_front #(
    parameter int MAX_WIDTH = sdfd_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_accept,
    input  wire sdfd_pkg::in_item_t                    in_item,
    input  wire logic                                  cfg_write,
    input  wire logic [sdfd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [sdfd_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output      logic                                  win_valid,
    output      sdfd_pkg::window_t                     win,
    output      sdfd_pkg::meta_t                       win_meta
);

    localparam int EB    = sdfd_pkg::ELEV_BITS;
    localparam int RB    = sdfd_pkg::ROW_BITS;
    localparam int DB    = sdfd_pkg::CFG_DATA_BITS;
    localparam int CBITS = $clog2(MAX_WIDTH);
    localparam int WBITS = $clog2(MAX_WIDTH + 1);
    localparam int WIDTH_RST = (MAX_WIDTH < sdfd_pkg::DIM_RESET) ?
                               MAX_WIDTH : sdfd_pkg::DIM_RESET;
    localparam logic [DB-1:0] WIDTH_HI = (MAX_WIDTH > 8191) ?
                                         {DB{1'b1}} : DB'(MAX_WIDTH);
    localparam logic [DB-1:0] HEIGHT_HI = DB'(sdfd_pkg::ROW_LIMIT);

    logic [WBITS-1:0] width_reg, width_next;
    logic [RB-1:0]    height_reg, height_next;
    logic [CBITS-1:0] col_reg, col_next;
    logic [RB-1:0]    row_reg, row_next;

    logic                s1_valid_reg;
    logic [CBITS-1:0]    s1_col_reg;
    sdfd_pkg::elev_t     s1_sample_reg;
    sdfd_pkg::meta_t     s1_meta_reg;
    logic                fwd_hit_reg;
    logic [2*EB-1:0]     fwd_data_reg;
    logic                s2_valid_reg;
    sdfd_pkg::meta_t     s2_meta_reg;
    sdfd_pkg::window_t   window_reg;

    logic [2*EB-1:0]  rd_word;
    logic [2*EB-1:0]  line_word;
    sdfd_pkg::elev_t  top_cell;
    sdfd_pkg::elev_t  mid_cell;
    sdfd_pkg::elev_t  sample;

    logic             col_nz;
    logic [WBITS-1:0] col_w;
    logic [WBITS-1:0] col_inc;
    logic [WBITS-1:0] cx;
    logic [31:0]      cx32;
    logic [RB-1:0]    cy;
    logic             row_ok;
    sdfd_pkg::meta_t  meta0;
    logic [31:0]      clamp32;

    // ---------------- entry stage: position and window coordinates
    assign sample = in_item.func ? '0 : in_item.elevation;
    assign col_nz = (col_reg != '0);
    assign col_w  = WBITS'(col_reg);
    assign col_inc = col_w + WBITS'(1);
    assign cx32   = 32'(cx);

    always_comb
    begin
        // centre lags one row plus one cell; column 0 points at the row before last
        if (col_nz)
        begin
            cx     = col_w - WBITS'(1);
            cy     = row_reg - RB'(1);
            row_ok = (row_reg >= RB'(1));
        end
        else
        begin
            cx     = width_reg - WBITS'(1);
            cy     = row_reg - RB'(2);
            row_ok = (row_reg >= RB'(2));
        end

        meta0.emit     = row_ok && (cy < height_reg);
        meta0.left_ok  = (cx != '0);
        meta0.right_ok = (cx != (width_reg - WBITS'(1)));
        meta0.up_ok    = (cy != '0);
        meta0.down_ok  = (cy != (height_reg - RB'(1)));
        meta0.last     = !meta0.right_ok && !meta0.down_ok;
        meta0.cell_col = cx32[sdfd_pkg::COORD_BITS-1:0];
        meta0.cell_row = cy[sdfd_pkg::COORD_BITS-1:0];
    end

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        clamp32     = '0;

        if (cfg_write)
        begin
            unique case (cfg_index)
                sdfd_pkg::REG_GRID_WIDTH:
                begin
                    clamp32    = 32'(sdfd_pkg::clamp_dim(cfg_data, WIDTH_HI));
                    width_next = clamp32[WBITS-1:0];
                    col_next   = '0;
                    row_next   = '0;
                end
                sdfd_pkg::REG_GRID_HEIGHT:
                begin
                    height_next = sdfd_pkg::clamp_dim(cfg_data, HEIGHT_HI);
                    col_next    = '0;
                    row_next    = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (in_accept)
        begin
            if (col_inc >= width_reg)
            begin
                col_next = '0;
                row_next = (row_reg == sdfd_pkg::ROW_MAX) ? row_reg : row_reg + RB'(1);
            end
            else
            begin
                col_next = col_inc[CBITS-1:0];
            end
            if (meta0.emit && meta0.last)
            begin
                col_next = '0;
                row_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WBITS'(WIDTH_RST);
            height_reg <= RB'(sdfd_pkg::DIM_RESET);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    // ---------------- line stores: {upper, middle} per column
    sdfd_ram #(
        .WIDTH (2 * EB),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata ({mid_cell, s1_sample_reg}),
        .raddr (col_reg),
        .rdata (rd_word)
    );

    // one-column rows read the entry written in the same cycle
    assign line_word = fwd_hit_reg ? fwd_data_reg : rd_word;
    assign top_cell  = line_word[2*EB-1:EB];
    assign mid_cell  = line_word[EB-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
            window_reg   <= '0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
            fwd_hit_reg  <= in_accept && s1_valid_reg && (col_reg == s1_col_reg);
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                window_reg[0] <= window_reg[1];
                window_reg[1] <= window_reg[2];
                window_reg[2] <= top_cell;
                window_reg[3] <= window_reg[4];
                window_reg[4] <= window_reg[5];
                window_reg[5] <= mid_cell;
                window_reg[6] <= window_reg[7];
                window_reg[7] <= window_reg[8];
                window_reg[8] <= s1_sample_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_col_reg    <= col_reg;
        s1_sample_reg <= sample;
        s1_meta_reg   <= meta0;
        fwd_data_reg  <= {mid_cell, s1_sample_reg};
        s2_meta_reg   <= s1_meta_reg;
    end

    assign win_valid = s2_valid_reg;
    assign win       = window_reg;
    assign win_meta  = s2_meta_reg;

endmodule

`default_nettype wire

>>> rtl/sdfd_select.sv
`default_nettype none

module sdfd_select (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  win_valid,
    input  wire sdfd_pkg::window_t     win,
    input  wire sdfd_pkg::meta_t       win_meta,
    output      logic                  retire,
    output      logic                  push,
    output      sdfd_pkg::out_item_t   push_item
);

    localparam int SB = sdfd_pkg::SLOPE_BITS;
    localparam int NB = sdfd_pkg::NUM_NB;
    localparam logic [NB-1:0] DIAG_MASK = 8'b1010_0101;

    logic [NB-1:0]              nb_ok;
    sdfd_pkg::cand_t [NB-1:0]   slope_c;

    logic                       s3_valid_reg, s4_valid_reg, s5_valid_reg;
    sdfd_pkg::meta_t            s3_meta_reg, s4_meta_reg, s5_meta_reg;
    sdfd_pkg::cand_t [NB-1:0]   s3_cand_reg;
    sdfd_pkg::cand_t [3:0]      s4_cand_reg;
    sdfd_pkg::cand_t [1:0]      s5_cand_reg;
    sdfd_pkg::cand_t            best;

    assign nb_ok = {
        win_meta.down_ok & win_meta.right_ok,
        win_meta.down_ok,
        win_meta.down_ok & win_meta.left_ok,
        win_meta.right_ok,
        win_meta.left_ok,
        win_meta.up_ok & win_meta.right_ok,
        win_meta.up_ok,
        win_meta.up_ok & win_meta.left_ok
    };

    // per-neighbor slope; centre sits at window index 4
    always_comb
    begin
        sdfd_pkg::elev_t centre;
        sdfd_pkg::elev_t nb;
        sdfd_pkg::elev_t drop;
        centre = win[4];
        for (int k = 0; k < NB; k++)
        begin
            nb   = (k < 4) ? win[k] : win[k + 1];
            drop = centre - nb;
            slope_c[k].code = sdfd_pkg::CODE_BITS'(k);
            if (nb_ok[k] && (nb < centre))
            begin
                if (DIAG_MASK[k])
                    slope_c[k].slope = SB'(drop) * SB'(sdfd_pkg::DIAG_SCALE);
                else
                    slope_c[k].slope = SB'(drop) << sdfd_pkg::ORTHO_SHIFT;
            end
            else
            begin
                slope_c[k].slope = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= win_valid;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // compare tree, earlier neighbor wins ties at every level
    always_ff @(posedge clk)
    begin
        s3_meta_reg <= win_meta;
        s3_cand_reg <= slope_c;
        s4_meta_reg <= s3_meta_reg;
        for (int i = 0; i < 4; i++)
        begin
            s4_cand_reg[i] <= sdfd_pkg::pick(s3_cand_reg[2*i], s3_cand_reg[2*i + 1]);
        end
        s5_meta_reg <= s4_meta_reg;
        for (int i = 0; i < 2; i++)
        begin
            s5_cand_reg[i] <= sdfd_pkg::pick(s4_cand_reg[2*i], s4_cand_reg[2*i + 1]);
        end
    end

    assign best = sdfd_pkg::pick(s5_cand_reg[0], s5_cand_reg[1]);

    always_comb
    begin
        push_item.slope_q16      = best.slope;
        push_item.direction_code = (best.slope == '0) ? sdfd_pkg::DIR_NONE : best.code;
        push_item.cell_col       = s5_meta_reg.cell_col;
        push_item.cell_row       = s5_meta_reg.cell_row;
        push_item.frame_last     = s5_meta_reg.last;
    end

    assign retire = s5_valid_reg;
    assign push   = s5_valid_reg && s5_meta_reg.emit;

endmodule

`default_nettype wire

>>> rtl/sdfd_outq.sv
`default_nettype none

module sdfd_outq (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire sdfd_pkg::out_item_t   push_item,
    input  wire logic                  pop,
    output      logic                  out_valid,
    output      sdfd_pkg::out_item_t   out_item
);

    localparam int DEPTH = sdfd_pkg::OUTQ_DEPTH;
    localparam int PBITS = $clog2(DEPTH);
    localparam int NBITS = $clog2(DEPTH + 1);

    sdfd_pkg::out_item_t slot_reg [DEPTH];
    logic [PBITS-1:0]    head_reg, head_next;
    logic [PBITS-1:0]    tail_reg, tail_next;
    logic [NBITS-1:0]    count_reg, count_next;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = (tail_reg == PBITS'(DEPTH - 1)) ? '0 : tail_reg + PBITS'(1);
        end
        if (pop)
        begin
            head_next = (head_reg == PBITS'(DEPTH - 1)) ? '0 : head_reg + PBITS'(1);
        end
        count_next = count_reg + NBITS'(push) - NBITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= push_item;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_item  = slot_reg[head_reg];

endmodule

`default_nettype wire

>>> rtl/sdfd_checker.sv
`default_nettype none

module sdfd_assertions (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 out_valid,
    input wire logic                                 out_ready,
    input wire sdfd_pkg::out_item_t                  out_item,
    input wire logic                                 cfg_valid,
    input wire logic                                 cfg_ready
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("stalled result changed or dropped");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_item.direction_code == sdfd_pkg::DIR_NONE)
                       == (out_item.slope_q16 == '0)))
        else $error("no-direction code and zero slope disagree");

    // orthogonal slopes are whole drops in Q16.16
    a_ortho_frac: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.direction_code == sdfd_pkg::DIR_N
                      || out_item.direction_code == sdfd_pkg::DIR_W
                      || out_item.direction_code == sdfd_pkg::DIR_E
                      || out_item.direction_code == sdfd_pkg::DIR_S)
        |-> (out_item.slope_q16[15:0] == '0))
        else $error("orthogonal slope has a fraction");

    a_reset_empty: assert property (@(posedge clk)
        !$past(rst_n) |-> !out_valid)
        else $error("result shown right after reset");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind steepest_descent_flow_direction_core sdfd_assertions u_sdfd_assertions (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

>>> bench/sdfd_checker.sv
`default_nettype none

module sdfd_checker (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    input  wire logic                                 in_ready,
    input  wire sdfd_pkg::in_item_t                   in_item,
    input  wire logic                                 out_valid,
    input  wire logic                                 out_ready,
    input  wire sdfd_pkg::out_item_t                  out_item,
    input  wire logic                                 cfg_valid,
    input  wire logic                                 cfg_ready,
    input  wire logic [sdfd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [sdfd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output int                                        mismatches,
    output int                                        pending,
    output int                                        checked,
    output int                                        held_cycles
);

    localparam int STORE_DEPTH = sdfd_pkg::MAX_WIDTH_DEF;

    // the two rows above the incoming cell, one entry per column
    bit [sdfd_pkg::ELEV_BITS-1:0] upper_row  [STORE_DEPTH];
    bit [sdfd_pkg::ELEV_BITS-1:0] middle_row [STORE_DEPTH];
    sdfd_pkg::window_t            win;
    int                           next_col;
    int                           next_row;
    int                           grid_w;
    int                           grid_h;
    sdfd_pkg::out_item_t          flow_q[$];

    function automatic int clip_dim(input logic [sdfd_pkg::CFG_DATA_BITS-1:0] v,
                                    input int hi);
        int r;
        if (v == '0)
            r = 1;
        else if (int'(v) > hi)
            r = hi;
        else
            r = int'(v);
        return r;
    endfunction

    // one cell enters the window; queue the flow result it releases, if any
    task automatic absorb_cell(input sdfd_pkg::in_item_t it);
        sdfd_pkg::elev_t     sample;
        sdfd_pkg::elev_t     above;
        sdfd_pkg::elev_t     level;
        sdfd_pkg::elev_t     nb;
        int                  cx;
        int                  cy;
        int                  nx;
        int                  ny;
        int                  pos;
        logic [63:0]         gain;
        logic [63:0]         slope;
        logic [63:0]         best;
        sdfd_pkg::dir_t      code;
        sdfd_pkg::out_item_t res;
        sample = it.func ? '0 : it.elevation;
        above = upper_row[next_col];
        level = middle_row[next_col];
        upper_row[next_col] = level;
        middle_row[next_col] = sample;
        for (int k = 0; k < 3; k++)
        begin
            win[k*3]     = win[k*3 + 1];
            win[k*3 + 1] = win[k*3 + 2];
        end
        win[2] = above;
        win[5] = level;
        win[8] = sample;
        if (next_col > 0)
        begin
            cx = next_col - 1;
            cy = next_row - 1;
        end
        else
        begin
            // first column: centre is the end of the row before last
            cx = grid_w - 1;
            cy = next_row - 2;
        end
        next_col++;
        if (next_col >= grid_w)
        begin
            next_col = 0;
            if (next_row < int'(sdfd_pkg::ROW_MAX))
                next_row++;
        end
        if (cy >= 0 && cy < grid_h)
        begin
            best = '0;
            code = sdfd_pkg::DIR_NONE;
            for (int dy = -1; dy <= 1; dy++)
            begin
                for (int dx = -1; dx <= 1; dx++)
                begin
                    nx = cx + dx;
                    ny = cy + dy;
                    if (dx == 0 && dy == 0)
                        continue;
                    if (nx < 0 || nx >= grid_w || ny < 0 || ny >= grid_h)
                        continue;
                    nb = win[(dy + 1)*3 + dx + 1];
                    if (nb >= win[4])
                        continue;
                    gain = (dx != 0 && dy != 0) ? 64'(sdfd_pkg::DIAG_SCALE)
                                                : (64'd1 << sdfd_pkg::ORTHO_SHIFT);
                    slope = (64'(win[4]) - 64'(nb)) * gain;
                    pos = (dy + 1)*3 + dx + 1;
                    if (pos > 4)
                        pos--;
                    // strict compare: the earlier neighbor keeps a tie
                    if (slope > best)
                    begin
                        best = slope;
                        code = sdfd_pkg::dir_t'(pos);
                    end
                end
            end
            res.direction_code = code;
            res.slope_q16      = (best > 64'hFFFF_FFFF) ? '1
                                                        : best[sdfd_pkg::SLOPE_BITS-1:0];
            res.cell_col       = sdfd_pkg::COORD_BITS'(cx);
            res.cell_row       = sdfd_pkg::COORD_BITS'(cy);
            res.frame_last     = (cx == grid_w - 1) && (cy == grid_h - 1);
            flow_q.push_back(res);
            if (res.frame_last)
            begin
                next_col = 0;
                next_row = 0;
            end
        end
    endtask

    task automatic check_result(input sdfd_pkg::out_item_t got);
        sdfd_pkg::out_item_t want;
        logic                bad;
        if (flow_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: dir %0d slope %h col %0d row %0d last %0b",
                         got.direction_code, got.slope_q16, got.cell_col, got.cell_row,
                         got.frame_last);
        end
        else
        begin
            want = flow_q.pop_front();
            bad = (got.direction_code !== want.direction_code)
                || (got.slope_q16 !== want.slope_q16)
                || (got.cell_col !== want.cell_col)
                || (got.cell_row !== want.cell_row)
                || (got.frame_last !== want.frame_last);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch at result %0d", checked);
                    $display("  expected dir %0d slope %h col %0d row %0d last %0b",
                             want.direction_code, want.slope_q16, want.cell_col,
                             want.cell_row, want.frame_last);
                    $display("  actual   dir %0d slope %h col %0d row %0d last %0b",
                             got.direction_code, got.slope_q16, got.cell_col,
                             got.cell_row, got.frame_last);
                end
            end
        end
        checked++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win = '0;
            next_col = 0;
            next_row = 0;
            grid_w = sdfd_pkg::DIM_RESET;
            grid_h = sdfd_pkg::DIM_RESET;
            flow_q.delete();
            mismatches = 0;
            pending = 0;
            checked = 0;
            held_cycles = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (sdfd_pkg::cfg_reg_t'(cfg_index))
                    sdfd_pkg::REG_GRID_WIDTH:
                    begin
                        grid_w = clip_dim(cfg_data, sdfd_pkg::MAX_WIDTH_DEF);
                        next_col = 0;
                        next_row = 0;
                    end
                    sdfd_pkg::REG_GRID_HEIGHT:
                    begin
                        grid_h = clip_dim(cfg_data, sdfd_pkg::ROW_LIMIT);
                        next_col = 0;
                        next_row = 0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && in_ready)
                absorb_cell(in_item);
            if (in_valid && !in_ready)
                held_cycles++;
            if (out_valid && out_ready)
                check_result(out_item);
            pending = flow_q.size();
        end
    end

endmodule

`default_nettype wire

>>> bench/tb.sv
`default_nettype none

module tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 350;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_FLUSH  = 1'b1;

    // indexes with no register behind them
    localparam logic [sdfd_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [sdfd_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_3 = 2'd3;

    localparam int SENDER_IDLE[4]    = '{0, 57, 0, 9};
    localparam int RECEIVER_STALL[4] = '{0, 0, 57, 9};

    localparam sdfd_pkg::elev_t CROSS_3X3[9] = '{16'd10, 16'd0, 16'd10,
                                                 16'd0, 16'hFFFF, 16'd0,
                                                 16'd10, 16'd0, 16'd10};
    localparam sdfd_pkg::elev_t PIT_2X2[4]   = '{16'd5, 16'd5, 16'd5, 16'd0};

    typedef enum int {
        TERRAIN_RANDOM,
        TERRAIN_PLATEAU,
        TERRAIN_CLIFF,
        TERRAIN_RAMP
    } terrain_t;

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_ready;
    sdfd_pkg::in_item_t                  in_item;
    logic                                out_valid;
    logic                                out_ready;
    sdfd_pkg::out_item_t                 out_item;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [sdfd_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [sdfd_pkg::CFG_DATA_BITS-1:0]  cfg_data;

    int mismatches;
    int pending;
    int checked;
    int held_cycles;

    int idle_pct;
    int stall_pct;
    int hold_requests = 0;
    int hold_served = 0;
    int items_sent;
    int frames_sent;
    int cycle_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    steepest_descent_flow_direction_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sdfd_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .pending     (pending),
        .checked     (checked),
        .held_cycles (held_cycles)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("FAIL steepest_descent_flow_direction_core");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off whenever one is requested
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served++;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic push_cell(input logic flush, input sdfd_pkg::elev_t level);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= '{func: flush, elevation: level};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic write_reg(input logic [sdfd_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [sdfd_pkg::CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // sender pauses until every result is back and the pipe has emptied
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_grid(input int w, input int h);
        drain();
        write_reg(sdfd_pkg::REG_GRID_WIDTH, sdfd_pkg::CFG_DATA_BITS'(w));
        write_reg(sdfd_pkg::REG_GRID_HEIGHT, sdfd_pkg::CFG_DATA_BITS'(h));
    endtask

    function automatic sdfd_pkg::elev_t terrain(input terrain_t kind, input int r,
                                                input int c, input sdfd_pkg::elev_t base);
        sdfd_pkg::elev_t v;
        case (kind)
            TERRAIN_PLATEAU:
                v = base + sdfd_pkg::elev_t'($urandom_range(0, 2));
            TERRAIN_CLIFF:
                case ($urandom_range(0, 3))
                    0: v = '0;
                    1: v = '1;
                    default: v = sdfd_pkg::elev_t'($urandom);
                endcase
            TERRAIN_RAMP:
                v = base + sdfd_pkg::elev_t'(r*37) + sdfd_pkg::elev_t'(c*11)
                    + sdfd_pkg::elev_t'($urandom_range(0, 40));
            default:
                v = sdfd_pkg::elev_t'($urandom);
        endcase
        return v;
    endfunction

    // one frame of cells, then one row plus one cell of padding;
    // a cut at cell index stops it there with no padding
    task automatic send_frame(input int w, input int h, input terrain_t kind, input int cut);
        sdfd_pkg::elev_t base;
        int              n;
        base = sdfd_pkg::elev_t'($urandom);
        n = 0;
        for (int r = 0; r < h && n != cut; r++)
        begin
            for (int c = 0; c < w && n != cut; c++)
            begin
                // occasional flush inside the frame reads as a zero cell
                if ($urandom_range(0, 99) < 4)
                    push_cell(FUNC_FLUSH, sdfd_pkg::elev_t'($urandom));
                else
                    push_cell(FUNC_SAMPLE, terrain(kind, r, c, base));
                n++;
            end
        end
        if (n != cut)
        begin
            for (int k = 0; k <= w; k++)
            begin
                if ($urandom_range(0, 99) < 80)
                    push_cell(FUNC_FLUSH, sdfd_pkg::elev_t'($urandom));
                else
                    push_cell(FUNC_SAMPLE, sdfd_pkg::elev_t'($urandom));
            end
            frames_sent++;
        end
    endtask

    initial
    begin
        int  w;
        int  h;
        int  cut;
        int  target;
        bit  fresh;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_pct = 0;
        stall_pct = 0;
        items_sent = 0;
        frames_sent = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // hand-built frames: four-way tie at the peak, corner ties, pits, single cell
        idle_pct = 20;
        stall_pct = 20;
        set_grid(3, 3);
        foreach (CROSS_3X3[i])
            push_cell(FUNC_SAMPLE, CROSS_3X3[i]);
        repeat (4) push_cell(FUNC_FLUSH, '1);
        set_grid(2, 2);
        foreach (PIT_2X2[i])
            push_cell(FUNC_SAMPLE, PIT_2X2[i]);
        repeat (3) push_cell(FUNC_SAMPLE, sdfd_pkg::elev_t'($urandom));
        set_grid(1, 1);
        push_cell(FUNC_SAMPLE, 16'd7);
        repeat (2) push_cell(FUNC_FLUSH, '0);
        frames_sent += 3;

        // out-of-range register values: widest single row, then tallest single
        // column, each cut short
        idle_pct = 0;
        stall_pct = 0;
        drain();
        write_reg(sdfd_pkg::REG_GRID_WIDTH, '1);
        write_reg(sdfd_pkg::REG_GRID_HEIGHT, '0);
        send_frame(sdfd_pkg::MAX_WIDTH_DEF, 1, TERRAIN_RANDOM, 40);
        drain();
        write_reg(sdfd_pkg::REG_GRID_WIDTH, '0);
        write_reg(sdfd_pkg::REG_GRID_HEIGHT, '1);
        send_frame(1, sdfd_pkg::ROW_LIMIT, TERRAIN_PLATEAU, 60);

        // a write mid-frame restarts it; spare indexes change nothing
        set_grid(5, 4);
        send_frame(5, 4, TERRAIN_RAMP, 13);
        drain();
        write_reg(sdfd_pkg::REG_GRID_HEIGHT, sdfd_pkg::CFG_DATA_BITS'(4));
        write_reg(REG_SPARE_2, sdfd_pkg::CFG_DATA_BITS'($urandom));
        write_reg(REG_SPARE_3, sdfd_pkg::CFG_DATA_BITS'($urandom));
        send_frame(5, 4, TERRAIN_CLIFF, -1);

        for (int p = 0; p < 4; p++)
        begin
            idle_pct = SENDER_IDLE[p];
            stall_pct = RECEIVER_STALL[p];
            target = items_sent + PHASE_ITEMS;
            fresh = 1'b1;
            w = 8;
            h = 6;
            while (items_sent < target)
            begin
                if (fresh || $urandom_range(0, 99) < 40)
                begin
                    if (!fresh)
                    begin
                        w = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70)
                                                        : $urandom_range(1, 10);
                        h = $urandom_range(1, 6);
                    end
                    set_grid(w, h);
                    // result side holds off while the sender keeps pushing
                    if (fresh && p == 0)
                        hold_requests++;
                    fresh = 1'b0;
                end
                cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, w*h - 1) : -1;
                send_frame(w, h, terrain_t'($urandom_range(0, 3)), cut);
                if (cut >= 0)
                begin
                    drain();
                    write_reg(sdfd_pkg::REG_GRID_WIDTH, sdfd_pkg::CFG_DATA_BITS'(w));
                end
            end
        end

        drain();
        $display("ran %0d frames from 1x1 to 70 wide plus clamped sizes, %0d input transactions",
                 frames_sent, items_sent);
        $display("checked %0d results; input held off %0d cycles by a full pipe",
                 checked, held_cycles);
        if (mismatches == 0 && pending == 0)
            $display("PASS steepest_descent_flow_direction_core");
        else
            $display("FAIL steepest_descent_flow_direction_core");
        $finish;
    end

endmodule

`default_nettype wire
